// ----- design/sbd_pkg.sv -----
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and constants for the button debounce event scanner.
// ----------------------------------------------------------------------------
package sbd_pkg;

	localparam int LEVEL_W        = 6;
	localparam int TIME_W         = 16;
	localparam int BTN_W          = 3;
	localparam int NUM_BUTTONS_DEF = 6;

	localparam logic [TIME_W-1:0] PERIOD_RESET = 16'd2500;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_DB_DOWN = 2'd1,
		PH_WAIT_UP = 2'd2,
		PH_DB_UP   = 2'd3
	} phase_t;

	localparam logic KIND_PUSHED   = 1'b0;
	localparam logic KIND_RELEASED = 1'b1;

	// what one button reports for the scan under way
	typedef struct packed {
		logic pushed;
		logic released;
	} cell_ev_t;

endpackage

// ----- design/sbd_scan_if.sv -----
// ----------------------------------------------------------------------------
// sbd_scan_if
// Scan channel: raw button levels and the timer value of one scan.
// ----------------------------------------------------------------------------
interface sbd_scan_if;
	logic                        valid;
	logic                        ready;
	logic [sbd_pkg::LEVEL_W-1:0] button_levels;
	logic [sbd_pkg::TIME_W-1:0]  now_time;

	modport source (output valid, output button_levels, output now_time, input ready);
	modport sink   (input valid, input button_levels, input now_time, output ready);
endinterface

// ----- design/sbd_event_if.sv -----
// ----------------------------------------------------------------------------
// sbd_event_if
// Result channel: one word per scan, saying which button, if any, gave an event.
// ----------------------------------------------------------------------------
interface sbd_event_if;
	logic                      valid;
	logic                      ready;
	logic                      event_valid;
	logic [sbd_pkg::BTN_W-1:0] event_button;
	logic                      event_kind;

	modport source (output valid, output event_valid, output event_button,
		output event_kind, input ready);
	modport sink   (input valid, input event_valid, input event_button,
		input event_kind, output ready);
endinterface

// ----- design/sbd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// sbd_cfg_if
// Configuration write channel carrying the debounce period.
// ----------------------------------------------------------------------------
interface sbd_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [sbd_pkg::TIME_W-1:0] debounce_period;

	modport source (output valid, output debounce_period, input ready);
	modport sink   (input valid, input debounce_period, output ready);
endinterface

// ----- design/sbd_btn_cell.sv -----
// ----------------------------------------------------------------------------
// sbd_btn_cell
// Four-phase debounce machine for one button, with its phase start time.
// ----------------------------------------------------------------------------
module sbd_btn_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       level,
	input  logic [sbd_pkg::TIME_W-1:0] now_time,
	input  logic [sbd_pkg::TIME_W-1:0] period,
	input  logic                       commit,
	output sbd_pkg::cell_ev_t          ev
);

	sbd_pkg::phase_t             phase_q, phase_d;
	logic [sbd_pkg::TIME_W-1:0]  start_q, start_d;
	logic [sbd_pkg::TIME_W-1:0]  elapsed;
	logic                        settled;

	// modulo 2^16 difference, so a timer wrap needs no special handling
	assign elapsed = now_time - start_q;
	assign settled = (elapsed >= period);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sbd_pkg::PH_IDLE;
			start_q <= '0;
		end else if (commit) begin
			phase_q <= phase_d;
			start_q <= start_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		start_d     = start_q;
		ev.pushed   = 1'b0;
		ev.released = 1'b0;
		case (phase_q)
			sbd_pkg::PH_IDLE: begin
				if (level) begin
					phase_d   = sbd_pkg::PH_DB_DOWN;
					start_d   = now_time;
					ev.pushed = 1'b1;
				end
			end
			sbd_pkg::PH_DB_DOWN: begin
				if (settled) begin
					phase_d = sbd_pkg::PH_WAIT_UP;
					start_d = now_time;
				end
			end
			sbd_pkg::PH_WAIT_UP: begin
				if (!level) begin
					phase_d     = sbd_pkg::PH_DB_UP;
					start_d     = now_time;
					ev.released = 1'b1;
				end
			end
			sbd_pkg::PH_DB_UP: begin
				if (settled)
					phase_d = sbd_pkg::PH_IDLE;
			end
			default: begin
				phase_d = sbd_pkg::PH_IDLE;
			end
		endcase
	end

endmodule

// ----- design/six_button_debounce_event_scanner.sv -----
// ----------------------------------------------------------------------------
// six_button_debounce_event_scanner
// Debounces a row of buttons and reports press and release events per scan.
// ----------------------------------------------------------------------------
// Usage:
//   scan   - one word per scan: raw button levels and the free-running timer.
//   result - one word per scan: event_valid, event_button, event_kind.
//   cfg    - writes the debounce period in timer ticks; always ready. Write it
//            only while no scan is in flight.
// Each scan is registered on accept, then one pass through the button
// machines and the priority select loads the result register once that
// register is empty or its word is being taken. With result.ready high
// a scan is taken in every cycle. Buttons are checked from index 0 up and only
// the first one to give an event, plus those before it, update their state.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more scan; scan.ready drops only when both are full.
// Reset returns every button to idle with a zero start time, sets the period
// to 2500 ticks and empties both registers.
// ----------------------------------------------------------------------------
module six_button_debounce_event_scanner #(
	parameter int NUM_BUTTONS = sbd_pkg::NUM_BUTTONS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	sbd_scan_if.sink   scan,
	sbd_event_if.source result,
	sbd_cfg_if.sink    cfg
);

	logic [sbd_pkg::TIME_W-1:0]  period_q;

	logic                        valid_s1;
	logic [sbd_pkg::LEVEL_W-1:0] levels_s1;
	logic [sbd_pkg::TIME_W-1:0]  now_s1;

	logic                        valid_s2;
	logic                        evv_s2;
	logic [sbd_pkg::BTN_W-1:0]   btn_s2;
	logic                        kind_s2;

	logic                        advance;
	sbd_pkg::cell_ev_t           cell_ev [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]      ev_any;
	logic [NUM_BUTTONS-1:0]      commit;
	logic                        evv_d;
	logic [sbd_pkg::BTN_W-1:0]   btn_d;
	logic                        kind_d;

	assign advance   = valid_s1 && (!valid_s2 || result.ready);
	assign scan.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			period_q <= sbd_pkg::PERIOD_RESET;
		else if (cfg.valid)
			period_q <= cfg.debounce_period;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (scan.ready)
			valid_s1 <= scan.valid;
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			levels_s1 <= scan.button_levels;
			now_s1    <= scan.now_time;
		end
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
		logic level;
		if (i < sbd_pkg::LEVEL_W) begin : g_pin
			assign level = levels_s1[i];
		end else begin : g_nopin
			assign level = 1'b0;
		end

		sbd_btn_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.level    (level),
			.now_time (now_s1),
			.period   (period_q),
			.commit   (commit[i]),
			.ev       (cell_ev[i])
		);

		assign ev_any[i] = cell_ev[i].pushed | cell_ev[i].released;
	end

	// a button only moves if no lower index gave an event in this scan
	always_comb begin
		logic seen;
		seen   = 1'b0;
		commit = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			commit[i] = advance && !seen;
			seen      = seen | ev_any[i];
		end
	end

	always_comb begin
		evv_d  = 1'b0;
		btn_d  = '0;
		kind_d = sbd_pkg::KIND_PUSHED;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (ev_any[i]) begin
				evv_d  = 1'b1;
				btn_d  = sbd_pkg::BTN_W'(i);
				kind_d = cell_ev[i].released ? sbd_pkg::KIND_RELEASED
					: sbd_pkg::KIND_PUSHED;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (result.ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			evv_s2  <= evv_d;
			btn_s2  <= btn_d;
			kind_s2 <= kind_d;
		end
	end

	assign result.valid        = valid_s2;
	assign result.event_valid  = evv_s2;
	assign result.event_button = btn_s2;
	assign result.event_kind   = kind_s2;

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(ev_any & commit) <= 1)
		else $error("more than one button committed an event in a scan");

	a_no_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !evv_s2 |-> btn_s2 == '0 && kind_s2 == sbd_pkg::KIND_PUSHED)
		else $error("empty result carries a button or kind");

	a_event_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (|ev_any) |=> valid_s2 && evv_s2)
		else $error("event lost between scan and result register");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!scan.ready |-> valid_s1 && valid_s2 && !result.ready)
		else $error("scan stalled with room in the pipeline");

endmodule
